// ===== src/qbr_pkg.sv =====
package qbr_pkg;

    localparam int POINT_WIDTH = 24;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_STEPS   = 26;
    localparam int COEF_WIDTH  = 32;
    localparam int ACC_WIDTH   = 48;
    localparam int NUM_COEFS   = 5;
    localparam int IDX_WIDTH   = 3;
    localparam int STEP_WIDTH  = 5;

    localparam logic [IDX_WIDTH-1:0] REG_COEF_X4 = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_COEF_X3 = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_COEF_X2 = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_COEF_X1 = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_COEF_X0 = 3'd4;

    localparam logic STATUS_FOUND     = 1'b0;
    localparam logic STATUS_NO_BRACKET = 1'b1;

    // Sequencer states
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EVAL1  = 7'b0000010,
        ST_EVAL2  = 7'b0000100,
        ST_CHECK  = 7'b0001000,
        ST_MID    = 7'b0010000,
        ST_EVALM  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    // Handshake between the sequencer and the Horner chain
    typedef struct packed {
        logic start;
    } hrn_ctl_t;

    typedef struct packed {
        logic done;
        logic zero;
        logic neg;
    } hrn_sts_t;

endpackage

// ===== src/qbr_cell.sv =====
// One Horner stage: acc_out = sat(sat(floor(acc_in * x / 2^F)) + coef).
// Registered in order: two half-width partial products, then the combined, scaled, saturated sum plus coef.
module qbr_cell #(
    parameter int POINT_WIDTH = qbr_pkg::POINT_WIDTH,
    parameter int FRAC_BITS   = qbr_pkg::FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic signed [qbr_pkg::ACC_WIDTH-1:0]  acc_in,
    input  logic signed [POINT_WIDTH-1:0]         x_in,
    input  logic signed [qbr_pkg::COEF_WIDTH-1:0] coef,
    output logic                                  out_valid,
    output logic signed [qbr_pkg::ACC_WIDTH-1:0]  acc_out,
    output logic signed [POINT_WIDTH-1:0]         x_out
);
    localparam int AW = qbr_pkg::ACC_WIDTH;
    localparam int PW = AW + POINT_WIDTH;
    localparam int SW = PW - FRAC_BITS;
    localparam int LW = AW / 2;
    localparam int HW = AW - LW;

    logic signed [HW-1:0]             acc_hi;
    logic signed [LW:0]               acc_lo;
    logic signed [HW+POINT_WIDTH-1:0] phi_reg;
    logic signed [LW+POINT_WIDTH:0]   plo_reg;
    logic signed [PW-1:0]             prod;
    logic signed [POINT_WIDTH-1:0]    xp_reg;
    logic                             v1_reg;
    logic signed [SW-1:0]             scaled;
    logic signed [AW-1:0]             sat_prod;
    logic signed [AW:0]               sum;
    logic signed [AW-1:0]             acc_next;
    logic signed [AW-1:0]             acc_reg;
    logic signed [POINT_WIDTH-1:0]    x_reg;
    logic                             v2_reg;

    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

    // Split the accumulator: signed upper half, zero-extended lower half
    assign acc_hi = acc_in[AW-1:LW];
    assign acc_lo = {1'b0, acc_in[LW-1:0]};

    // Arithmetic shift floors toward minus infinity
    always_comb
    begin
        prod   = (PW'(phi_reg) <<< LW) + PW'(plo_reg);
        scaled = SW'(prod >>> FRAC_BITS);
        if (scaled > SW'(ACC_MAX))
            sat_prod = ACC_MAX;
        else if (scaled < SW'(ACC_MIN))
            sat_prod = ACC_MIN;
        else
            sat_prod = AW'(scaled);
        sum = (AW+1)'(sat_prod) + (AW+1)'(coef);
        if (sum > (AW+1)'(ACC_MAX))
            acc_next = ACC_MAX;
        else if (sum < (AW+1)'(ACC_MIN))
            acc_next = ACC_MIN;
        else
            acc_next = AW'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        phi_reg <= acc_hi * x_in;
        plo_reg <= acc_lo * x_in;
        xp_reg  <= x_in;
        acc_reg <= acc_next;
        x_reg   <= xp_reg;
    end

    assign out_valid = v2_reg;
    assign acc_out   = acc_reg;
    assign x_out     = x_reg;
endmodule

// ===== src/qbr_chain.sv =====
// Four Horner cells in a row; each cell passes its accumulator and point on.
module qbr_chain #(
    parameter int POINT_WIDTH = qbr_pkg::POINT_WIDTH,
    parameter int FRAC_BITS   = qbr_pkg::FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  qbr_pkg::hrn_ctl_t                     ctl,
    input  logic signed [POINT_WIDTH-1:0]         x,
    input  logic signed [qbr_pkg::COEF_WIDTH-1:0] coefs [qbr_pkg::NUM_COEFS],
    output qbr_pkg::hrn_sts_t                     sts
);
    localparam int NC = qbr_pkg::NUM_COEFS - 1;

    logic                                 v   [NC+1];
    logic signed [qbr_pkg::ACC_WIDTH-1:0] acc [NC+1];
    logic signed [POINT_WIDTH-1:0]        xs  [NC+1];

    assign v[0]   = ctl.start;
    assign acc[0] = qbr_pkg::ACC_WIDTH'(coefs[0]);
    assign xs[0]  = x;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        qbr_cell #(
            .POINT_WIDTH(POINT_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (v[i]),
            .acc_in   (acc[i]),
            .x_in     (xs[i]),
            .coef     (coefs[i+1]),
            .out_valid(v[i+1]),
            .acc_out  (acc[i+1]),
            .x_out    (xs[i+1])
        );
    end

    assign sts.done = v[NC];
    assign sts.zero = (acc[NC] == '0);
    assign sts.neg  = acc[NC][qbr_pkg::ACC_WIDTH-1];
endmodule

// ===== src/quartic_bisection_root.sv =====
// Quartic bisection root finder. Each transfer on the input brings two bracket
// ends; p(x) is evaluated through a chain of four Horner cells, each of which
// registers its partial products, then the scaled and saturated sum. An item
// takes two evaluations to check the ends and up to MAX_STEPS more for
// bisection; the default MAX_STEPS is 26. One item is in work at a time; the
// next is taken once the result has been transferred.
module quartic_bisection_root #(
    parameter int POINT_WIDTH = qbr_pkg::POINT_WIDTH,
    parameter int FRAC_BITS   = qbr_pkg::FRAC_BITS,
    parameter int MAX_STEPS   = qbr_pkg::MAX_STEPS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [qbr_pkg::IDX_WIDTH-1:0]         cfg_index,
    input  logic [qbr_pkg::COEF_WIDTH-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [POINT_WIDTH-1:0]         first_point,
    input  logic signed [POINT_WIDTH-1:0]         second_point,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [POINT_WIDTH-1:0]         root,
    output logic                                  status
);
    localparam int SW = qbr_pkg::STEP_WIDTH;

    qbr_pkg::state_t state_reg, state_next;

    logic signed [qbr_pkg::COEF_WIDTH-1:0] coef_reg [qbr_pkg::NUM_COEFS];
    logic signed [POINT_WIDTH-1:0] x1_reg, x2_reg, low_reg, high_reg;
    logic signed [POINT_WIDTH-1:0] mid_reg, eval_x;
    logic signed [POINT_WIDTH-1:0] root_reg;
    logic                          status_reg;
    logic                          y1_zero_reg, y1_neg_reg;
    logic [SW-1:0]                 step_reg;
    logic                          start_reg;
    logic                          out_valid_reg;
    logic signed [POINT_WIDTH:0]   bsum;
    logic signed [POINT_WIDTH-1:0] mid_calc;

    qbr_pkg::hrn_ctl_t ctl;
    qbr_pkg::hrn_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < qbr_pkg::NUM_COEFS; i++)
                coef_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qbr_pkg::REG_COEF_X4: coef_reg[0] <= cfg_data;
                qbr_pkg::REG_COEF_X3: coef_reg[1] <= cfg_data;
                qbr_pkg::REG_COEF_X2: coef_reg[2] <= cfg_data;
                qbr_pkg::REG_COEF_X1: coef_reg[3] <= cfg_data;
                qbr_pkg::REG_COEF_X0: coef_reg[4] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign ctl.start = start_reg;

    qbr_chain #(
        .POINT_WIDTH(POINT_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_chain (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .x    (eval_x),
        .coefs(coef_reg),
        .sts  (sts)
    );

    assign in_ready  = (state_reg == qbr_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign root      = root_reg;
    assign status    = status_reg;

    // Floor midpoint: arithmetic shift of the widened sum
    assign bsum     = (POINT_WIDTH+1)'(low_reg) + (POINT_WIDTH+1)'(high_reg);
    assign mid_calc = POINT_WIDTH'(bsum >>> 1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qbr_pkg::ST_IDLE:  if (in_valid && in_ready) state_next = qbr_pkg::ST_EVAL1;
            qbr_pkg::ST_EVAL1: if (sts.done) state_next = qbr_pkg::ST_EVAL2;
            qbr_pkg::ST_EVAL2:
            begin
                if (sts.done)
                begin
                    if (y1_zero_reg || sts.zero || (y1_neg_reg == sts.neg))
                        state_next = qbr_pkg::ST_DONE;
                    else
                        state_next = qbr_pkg::ST_CHECK;
                end
            end
            qbr_pkg::ST_CHECK: state_next = qbr_pkg::ST_MID;
            qbr_pkg::ST_MID:
            begin
                if (mid_calc == mid_reg || step_reg == SW'(MAX_STEPS))
                    state_next = qbr_pkg::ST_DONE;
                else
                    state_next = qbr_pkg::ST_EVALM;
            end
            qbr_pkg::ST_EVALM:
            begin
                if (sts.done)
                    state_next = sts.zero ? qbr_pkg::ST_DONE : qbr_pkg::ST_MID;
            end
            qbr_pkg::ST_DONE:  if (out_ready) state_next = qbr_pkg::ST_IDLE;
            default:           state_next = qbr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qbr_pkg::ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= 1'b0;
            case (state_reg)
                qbr_pkg::ST_IDLE:
                begin
                    if (in_valid)
                        start_reg <= 1'b1;
                end
                qbr_pkg::ST_EVAL1:
                begin
                    if (sts.done)
                        start_reg <= 1'b1;
                end
                qbr_pkg::ST_EVAL2:
                begin
                    if (sts.done)
                    begin
                        if (y1_zero_reg || sts.zero || (y1_neg_reg == sts.neg))
                            out_valid_reg <= 1'b1;
                    end
                end
                qbr_pkg::ST_CHECK:
                    step_reg <= '0;
                qbr_pkg::ST_MID:
                begin
                    if (mid_calc == mid_reg || step_reg == SW'(MAX_STEPS))
                        out_valid_reg <= 1'b1;
                    else
                    begin
                        start_reg <= 1'b1;
                        step_reg  <= step_reg + 1'b1;
                    end
                end
                qbr_pkg::ST_EVALM:
                begin
                    if (sts.done && sts.zero)
                        out_valid_reg <= 1'b1;
                end
                qbr_pkg::ST_DONE:
                begin
                    if (out_ready)
                        out_valid_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            qbr_pkg::ST_IDLE:
            begin
                x1_reg <= first_point;
                x2_reg <= second_point;
                eval_x <= first_point;
            end
            qbr_pkg::ST_EVAL1:
            begin
                if (sts.done)
                begin
                    y1_zero_reg <= sts.zero;
                    y1_neg_reg  <= sts.neg;
                    eval_x      <= x2_reg;
                end
            end
            qbr_pkg::ST_EVAL2:
            begin
                if (sts.done)
                begin
                    status_reg <= qbr_pkg::STATUS_FOUND;
                    if (y1_zero_reg)
                        root_reg <= x1_reg;
                    else if (sts.zero)
                        root_reg <= x2_reg;
                    else if (y1_neg_reg == sts.neg)
                    begin
                        root_reg   <= '0;
                        status_reg <= qbr_pkg::STATUS_NO_BRACKET;
                    end
                end
            end
            qbr_pkg::ST_CHECK:
            begin
                low_reg  <= y1_neg_reg ? x1_reg : x2_reg;
                high_reg <= y1_neg_reg ? x2_reg : x1_reg;
                mid_reg  <= y1_neg_reg ? x2_reg : x1_reg;
            end
            qbr_pkg::ST_MID:
            begin
                if (step_reg == SW'(MAX_STEPS))
                    root_reg <= mid_reg;
                else
                begin
                    mid_reg  <= mid_calc;
                    eval_x   <= mid_calc;
                    root_reg <= mid_calc;
                end
            end
            qbr_pkg::ST_EVALM:
            begin
                if (sts.done && !sts.zero)
                begin
                    if (sts.neg)
                        low_reg <= mid_reg;
                    else
                        high_reg <= mid_reg;
                end
            end
            default: ;
        endcase
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(root) && $stable(status))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");
    a_step_cap: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= SW'(MAX_STEPS))
        else $error("step count past cap");
    a_nobracket_root: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == qbr_pkg::STATUS_NO_BRACKET |-> root == '0)
        else $error("no-bracket result with nonzero root");
endmodule
